// File: sv/thread_id_deque_with_keyed_removal_assert.svh
// Assertion macros for the thread ID deque sequencer.
`ifndef THREAD_ID_DEQUE_WITH_KEYED_REMOVAL_ASSERT_SVH
`define THREAD_ID_DEQUE_WITH_KEYED_REMOVAL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define TIDQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tidq assertion failed");

// Implication checked in the same cycle outside reset.
`define TIDQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tidq assertion failed");

`else

`define TIDQ_ASSERT(label, prop)
`define TIDQ_ASSERT_IMP(label, ante, cons)

`endif

`endif

// File: sv/tidq_pkg.sv
// Package: constants, command and status codes, and types for the thread ID deque.
`default_nettype none

package tidq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_LEFT,
        CELL_SHIFT_RIGHT,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wr;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/thread_id_deque_with_keyed_removal.sv
// Top level of the thread ID deque: sequencer plus a chain of ID cells.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cmd     | cmd_valid, cmd_ready, cmd, thread_id      | in
//  rsp     | rsp_valid, rsp_ready, status, result_id,  | out
//          | position, entry_count                     |
//
// Push, pop, unused code: the accepted command passes the execute state, and the
// result state then loads the result word. Remove and find rotate one entry past
// the head cell per cycle through every entry before the result state (no scan when empty).
// No clearing pass after reset; slots are only read below the entry count.
// A stalled result word holds in the output register while the next command
// is accepted; that command waits in its result stage until the register frees.
`default_nettype none

module thread_id_deque_with_keyed_removal #(
    parameter int DEPTH    = tidq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tidq_pkg::ID_WIDTH_DEF,
    localparam int CW      = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire logic [tidq_pkg::CMD_W-1:0]  cmd,
    input  wire logic [ID_WIDTH-1:0]         thread_id,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic      [tidq_pkg::STAT_W-1:0] status,
    output logic      [ID_WIDTH-1:0]         result_id,
    output logic      [tidq_pkg::POS_W-1:0]  position,
    output logic      [CW-1:0]               entry_count
);
    import tidq_pkg::*;

    localparam int SW = $clog2(DEPTH);

    cell_ctl_t           cell_ctl;
    logic [SW-1:0]       cell_sel;
    logic [ID_WIDTH-1:0] cell_wdata;
    logic [ID_WIDTH-1:0] slots [DEPTH];
    logic [ID_WIDTH-1:0] taps  [DEPTH];
    logic [ID_WIDTH-1:0] tail_tap;

    tidq_ctrl #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .thread_id   (thread_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .result_id   (result_id),
        .position    (position),
        .entry_count (entry_count),
        .head        (slots[0]),
        .tail_tap    (tail_tap),
        .cell_ctl    (cell_ctl),
        .cell_sel    (cell_sel),
        .cell_wdata  (cell_wdata)
    );

    // chain of slots, front at cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_WIDTH-1:0] left_in;
        logic [ID_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = cell_wdata;
        end
        else
        begin : g_mid_l
            assign left_in = slots[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = slots[i];
        end
        else
        begin : g_mid_r
            assign right_in = slots[i+1];
        end

        tidq_cell #(
            .IDX   (i),
            .ID_W  (ID_WIDTH),
            .SEL_W (SW)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .sel      (cell_sel),
            .wdata    (cell_wdata),
            .left_in  (left_in),
            .right_in (right_in),
            .slot     (slots[i]),
            .tap      (taps[i])
        );
    end

    // only the selected cell drives its tap, so an OR picks the back entry
    always_comb
    begin
        tail_tap = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            tail_tap = tail_tap | taps[k];
        end
    end

endmodule

`default_nettype wire

// File: sv/tidq_cell.sv
// One slot of the ID chain: holds an ID and trades it with its neighbors.
`default_nettype none

module tidq_cell #(
    parameter int IDX   = 0,
    parameter int ID_W  = 16,
    parameter int SEL_W = 4
) (
    input  wire logic              clk,
    input  wire tidq_pkg::cell_ctl_t ctl,
    input  wire logic [SEL_W-1:0]  sel,
    input  wire logic [ID_W-1:0]   wdata,
    input  wire logic [ID_W-1:0]   left_in,
    input  wire logic [ID_W-1:0]   right_in,
    output logic      [ID_W-1:0]   slot,
    output logic      [ID_W-1:0]   tap
);
    import tidq_pkg::*;

    localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

    logic [ID_W-1:0] slot_reg;
    logic [ID_W-1:0] slot_next;
    logic            below_sel;
    logic            at_sel;

    assign below_sel = MY_IDX < sel;
    assign at_sel    = MY_IDX == sel;

    // next slot value
    always_comb
    begin
        slot_next = slot_reg;
        case (ctl.op)
            CELL_SHIFT_LEFT:
            begin
                if (below_sel)
                begin
                    slot_next = right_in;
                end
                else if (at_sel && ctl.wr)
                begin
                    slot_next = wdata;
                end
            end
            CELL_SHIFT_RIGHT:
            begin
                slot_next = (IDX == 0) ? wdata : left_in;
            end
            CELL_WRITE:
            begin
                if (at_sel)
                begin
                    slot_next = wdata;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;
    assign tap  = at_sel ? slot_reg : '0;

endmodule

`default_nettype wire

// File: sv/tidq_ctrl.sv
// Command sequencer: runs each command over the cell chain and holds the result word.
`default_nettype none

module tidq_ctrl #(
    parameter int DEPTH    = tidq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tidq_pkg::ID_WIDTH_DEF,
    localparam int SW      = $clog2(DEPTH),
    localparam int CW      = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire logic [tidq_pkg::CMD_W-1:0]  cmd,
    input  wire logic [ID_WIDTH-1:0]         thread_id,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic      [tidq_pkg::STAT_W-1:0] status,
    output logic      [ID_WIDTH-1:0]         result_id,
    output logic      [tidq_pkg::POS_W-1:0]  position,
    output logic      [CW-1:0]               entry_count,
    input  wire logic [ID_WIDTH-1:0]         head,
    input  wire logic [ID_WIDTH-1:0]         tail_tap,
    output tidq_pkg::cell_ctl_t              cell_ctl,
    output logic      [SW-1:0]               cell_sel,
    output logic      [ID_WIDTH-1:0]         cell_wdata
);
    import tidq_pkg::*;

    `include "thread_id_deque_with_keyed_removal_assert.svh"

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       left_reg, left_next;
    logic [POS_W-1:0]    step_reg, step_next;
    logic                found_reg, found_next;
    logic [STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic [ID_WIDTH-1:0] res_id_reg, res_id_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [ID_WIDTH-1:0] result_id_reg, result_id_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [CW-1:0]       entry_count_reg, entry_count_next;

    logic                full;
    logic                empty;
    logic                hit;
    logic                out_free;
    logic [SW-1:0]       last_sel;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign hit      = !found_reg && (head == key_reg);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign last_sel = SW'(count_reg - ONE_CNT);

    // next state, chain control and result
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        left_next        = left_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        res_stat_next    = res_stat_reg;
        res_id_next      = res_id_reg;
        res_pos_next     = res_pos_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        result_id_next   = result_id_reg;
        position_next    = position_reg;
        entry_count_next = entry_count_reg;
        cell_ctl         = '{op: CELL_HOLD, wr: 1'b0};
        cell_sel         = last_sel;
        cell_wdata       = key_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = thread_id;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_stat_next = ST_OK;
                res_id_next   = '0;
                res_pos_next  = '0;
                state_next    = S_RESP;
                case (cmd_reg)
                    CMD_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            res_stat_next = ST_FULL;
                        end
                        else
                        begin
                            cell_ctl   = '{op: CELL_SHIFT_RIGHT, wr: 1'b1};
                            count_next = count_reg + ONE_CNT;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            res_stat_next = ST_FULL;
                        end
                        else
                        begin
                            cell_ctl   = '{op: CELL_WRITE, wr: 1'b1};
                            cell_sel   = SW'(count_reg);
                            count_next = count_reg + ONE_CNT;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            res_stat_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_id_next = head;
                            cell_ctl    = '{op: CELL_SHIFT_LEFT, wr: 1'b0};
                            count_next  = count_reg - ONE_CNT;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (empty)
                        begin
                            res_stat_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_id_next = tail_tap;
                            count_next  = count_reg - ONE_CNT;
                        end
                    end
                    CMD_REMOVE, CMD_FIND:
                    begin
                        res_stat_next = ST_EMPTY;
                        if (!empty)
                        begin
                            left_next  = count_reg;
                            step_next  = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_stat_next = ST_OK;
                    end
                endcase
            end

            // one entry passes the head per cycle; kept entries rotate to the tail
            S_SCAN:
            begin
                if (hit)
                begin
                    found_next    = 1'b1;
                    res_stat_next = ST_OK;
                    res_id_next   = head;
                    res_pos_next  = step_reg;
                end
                if (hit && (cmd_reg == CMD_REMOVE))
                begin
                    cell_ctl   = '{op: CELL_SHIFT_LEFT, wr: 1'b0};
                    count_next = count_reg - ONE_CNT;
                end
                else
                begin
                    cell_ctl   = '{op: CELL_SHIFT_LEFT, wr: 1'b1};
                    cell_wdata = head;
                end
                step_next = step_reg + POS_W'(1);
                left_next = left_reg - ONE_CNT;
                if (left_reg == ONE_CNT)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    status_next      = res_stat_reg;
                    result_id_next   = res_id_reg;
                    position_next    = res_pos_reg;
                    entry_count_next = count_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        step_reg        <= step_next;
        res_stat_reg    <= res_stat_next;
        res_id_reg      <= res_id_next;
        res_pos_reg     <= res_pos_next;
        status_reg      <= status_next;
        result_id_reg   <= result_id_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
    end

    assign cmd_ready   = state_reg == S_IDLE;
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign result_id   = result_id_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

    `TIDQ_ASSERT(a_count_bound, count_reg <= FULL_CNT)
    `TIDQ_ASSERT_IMP(a_scan_left, state_reg == S_SCAN, (left_reg != '0) && (count_reg >= left_reg))
    `TIDQ_ASSERT_IMP(a_miss_zero, rsp_valid_reg && (status_reg != ST_OK), (result_id_reg == '0) && (position_reg == '0))
    `TIDQ_ASSERT(a_count_step, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + ONE_CNT) || (count_reg + ONE_CNT == $past(count_reg)))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the thread ID deque: directed table, then random commands under idling and stalls.
`timescale 1ns / 1ps

module tb_top;
    import tidq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int IDW   = ID_WIDTH_DEF;
    localparam int CW    = $clog2(DEPTH + 1);

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDW-1:0]    result_id;
        logic [POS_W-1:0]  position;
        logic [CW-1:0]     entry_count;
    } rsp_word_t;

    // one line of the directed table; id advances by one on each repeat
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDW-1:0]   id;
        logic [4:0]       reps;
        logic             typed;
        rsp_word_t        word;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    logic [CMD_W-1:0]     cmd = '0;
    logic [IDW-1:0]       thread_id = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [IDW-1:0]       result_id;
    logic [POS_W-1:0]     position;
    logic [CW-1:0]        entry_count;

    // predicted list contents, front at index 0
    logic [IDW-1:0]       ready_list[$];
    rsp_word_t            pending_words[$];

    int send_idle_pct = 0;
    int rsp_idle_pct  = 0;
    int hold_len      = 0;
    int hold_req_id   = 0;
    int hold_ack_id   = 0;
    int hold_left     = 0;
    int fail_count    = 0;

    localparam rsp_word_t NO_WORD = '0;

    dir_row_t dir_rows [0:24] = '{
        // empty list: pops, remove and find all report empty
        '{CMD_POP_FRONT,  16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0, 5'd0}},
        '{CMD_POP_BACK,   16'h0000, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0, 5'd0}},
        '{CMD_REMOVE,     16'h1234, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0, 5'd0}},
        '{CMD_FIND,       16'h1234, 5'd1,  1'b1, '{ST_EMPTY, 16'h0000, 4'd0, 5'd0}},
        // unused codes: ok, nothing changes; then push at both ends and find the back entry
        '{CMD_UNUSED6,    16'hFFFF, 5'd1,  1'b1, '{ST_OK,    16'h0000, 4'd0, 5'd0}},
        '{CMD_UNUSED7,    16'h0000, 5'd1,  1'b1, '{ST_OK,    16'h0000, 4'd0, 5'd0}},
        '{CMD_PUSH_BACK,  16'hFFFF, 5'd1,  1'b1, '{ST_OK,    16'h0000, 4'd0, 5'd1}},
        '{CMD_PUSH_FRONT, 16'h0000, 5'd1,  1'b1, '{ST_OK,    16'h0000, 4'd0, 5'd2}},
        '{CMD_FIND,       16'hFFFF, 5'd1,  1'b1, '{ST_OK,    16'hFFFF, 4'd1, 5'd2}},
        // duplicates: the one nearest the front is hit; then a miss and pops at both ends
        '{CMD_PUSH_BACK,  16'hA5A5, 5'd1,  1'b0, NO_WORD},
        '{CMD_PUSH_FRONT, 16'h5A5A, 5'd1,  1'b0, NO_WORD},
        '{CMD_PUSH_BACK,  16'hA5A5, 5'd1,  1'b0, NO_WORD},
        '{CMD_FIND,       16'hA5A5, 5'd1,  1'b0, NO_WORD},
        '{CMD_REMOVE,     16'hA5A5, 5'd1,  1'b0, NO_WORD},
        '{CMD_REMOVE,     16'h5A5A, 5'd1,  1'b0, NO_WORD},
        '{CMD_FIND,       16'h1111, 5'd1,  1'b0, NO_WORD},
        '{CMD_POP_FRONT,  16'h0000, 5'd1,  1'b0, NO_WORD},
        '{CMD_POP_BACK,   16'h0000, 5'd1,  1'b0, NO_WORD},
        // fill past full: the last pushes are dropped
        '{CMD_PUSH_BACK,  16'h0100, 5'd18, 1'b0, NO_WORD},
        '{CMD_PUSH_FRONT, 16'hBEEF, 5'd1,  1'b1, '{ST_FULL,  16'h0000, 4'd0, 5'd16}},
        // deepest slot
        '{CMD_FIND,       16'h010E, 5'd1,  1'b0, NO_WORD},
        '{CMD_REMOVE,     16'h010E, 5'd1,  1'b0, NO_WORD},
        '{CMD_PUSH_FRONT, 16'h7777, 5'd1,  1'b0, NO_WORD},
        // drain past empty
        '{CMD_POP_FRONT,  16'h0000, 5'd17, 1'b0, NO_WORD},
        '{CMD_UNUSED7,    16'h5555, 5'd1,  1'b1, '{ST_OK,    16'h0000, 4'd0, 5'd0}}
    };

    thread_id_deque_with_keyed_removal dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .thread_id   (thread_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .result_id   (result_id),
        .position    (position),
        .entry_count (entry_count)
    );

    always #4 clk = ~clk;

    // apply one command to the predicted list and return the result word
    function automatic rsp_word_t ready_list_step(input logic [CMD_W-1:0] c,
                                                  input logic [IDW-1:0] id);
        rsp_word_t w;
        int        hit;
        w   = '0;
        hit = -1;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (ready_list.size() >= DEPTH)
                    w.status = ST_FULL;
                else if (c == CMD_PUSH_FRONT)
                    ready_list.push_front(id);
                else
                    ready_list.push_back(id);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (ready_list.size() == 0)
                    w.status = ST_EMPTY;
                else if (c == CMD_POP_FRONT)
                    w.result_id = ready_list.pop_front();
                else
                    w.result_id = ready_list.pop_back();
            end
            CMD_REMOVE, CMD_FIND:
            begin
                for (int i = 0; i < ready_list.size() && hit < 0; i++)
                    if (ready_list[i] == id)
                        hit = i;
                if (hit < 0)
                    w.status = ST_EMPTY;
                else
                begin
                    w.result_id = ready_list[hit];
                    w.position  = hit[POS_W-1:0];
                    if (c == CMD_REMOVE)
                        ready_list.delete(hit);
                end
            end
            default:;
        endcase
        w.entry_count = CW'(ready_list.size());
        return w;
    endfunction

    // offer one command word; predict its result once accepted
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDW-1:0] id,
                             input logic typed, input rsp_word_t typed_word);
        rsp_word_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        thread_id <= id;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pred = ready_list_step(c, id);
        pending_words.push_back(typed ? typed_word : pred);
    endtask

    // sender pause until every result word is back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // random commands; push/pop balance is redrawn every 32 words so full and empty can both occur
    task automatic random_phase(input int n_items);
        logic [CMD_W-1:0] c;
        logic [IDW-1:0]   id;
        int               push_bias;
        int               r;
        push_bias = 50;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 32 == 0)
                case ($urandom_range(2))
                    0:       push_bias = 20;
                    1:       push_bias = 50;
                    default: push_bias = 85;
                endcase
            r = $urandom_range(99);
            if (r < 5)
                c = r[0] ? CMD_UNUSED6 : CMD_UNUSED7;
            else if ($urandom_range(99) < push_bias)
                c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
                case ($urandom_range(3))
                    0:       c = CMD_POP_FRONT;
                    1:       c = CMD_POP_BACK;
                    2:       c = CMD_REMOVE;
                    default: c = CMD_FIND;
                endcase
            // mostly hit live entries on lookups; small IDs breed duplicates
            if ((c == CMD_REMOVE || c == CMD_FIND) && ready_list.size() != 0
                && $urandom_range(9) < 7)
                id = ready_list[$urandom_range(ready_list.size() - 1)];
            else if ($urandom_range(1))
                id = IDW'($urandom_range(7));
            else
                id = IDW'($urandom_range(16'hFFFF));
            send_word(c, id, 1'b0, NO_WORD);
        end
    endtask

    // compare an accepted result word with the oldest prediction
    task automatic check_word();
        rsp_word_t want;
        if (pending_words.size() == 0)
        begin
            if (fail_count < 10)
                $display("ERROR: unexpected word status=%0d id=%h pos=%0d count=%0d",
                         status, result_id, position, entry_count);
            fail_count++;
        end
        else
        begin
            want = pending_words.pop_front();
            if (status !== want.status || result_id !== want.result_id
                || position !== want.position || entry_count !== want.entry_count)
            begin
                if (fail_count < 10)
                    $display("ERROR: exp status=%0d id=%h pos=%0d count=%0d, got %0d %h %0d %0d",
                             want.status, want.result_id, want.position, want.entry_count,
                             status, result_id, position, entry_count);
                fail_count++;
            end
        end
    endtask

    // receiver: random ready, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
                check_word();
            if (hold_req_id != hold_ack_id)
            begin
                hold_ack_id = hold_req_id;
                hold_left   = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_word(dir_rows[i].cmd, dir_rows[i].id + k[IDW-1:0],
                          dir_rows[i].typed, dir_rows[i].word);
        wait_drained();

        send_idle_pct = 24;
        rsp_idle_pct  = 45;
        random_phase(280);
        wait_drained();

        // receiver stalls while the sender keeps offering, so the input backs up
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        hold_len      = 80;
        hold_req_id++;
        random_phase(30);
        wait_drained();

        send_idle_pct = 45;
        rsp_idle_pct  = 24;
        random_phase(280);
        wait_drained();

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        random_phase(200);
        wait_drained();
        repeat (30) @(posedge clk);

        if (fail_count == 0 && pending_words.size() == 0)
            $display("thread_id_deque_with_keyed_removal test passed");
        else
            $display("thread_id_deque_with_keyed_removal test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("thread_id_deque_with_keyed_removal test failed");
        $finish;
    end

endmodule
